// ===== hdl/e2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2a_pkg
// Shared types, constants and arithmetic helpers for the Euler to
// axis-angle converter.
// ----------------------------------------------------------------------------
package e2a_pkg;

    // Default configuration
    localparam int FRAC_BITS_DEF = 13;
    localparam int STAGES_DEF    = 16;

    // Internal formats: signed Q30
    localparam int IFRAC = 30;
    localparam int RW    = 36;  // rotation datapath width
    localparam int QW    = 34;  // sine, cosine and quaternion width
    localparam int VW    = 38;  // vectoring datapath width

    // Port widths
    localparam int IN_W  = 15;
    localparam int ROT_W = 16;
    localparam int AX_W  = 15;

    // Half angles in 1/128 degree
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    // Degree to radian scaling: a*PI_Q30/23040 = a*Z_INT + a*Z_REM/23040
    localparam int Z_INT    = 146408;
    localparam int Z_REM    = 19106;
    // Remaining divide by 45 after a shift by 9, exact below 2^19
    localparam int Z_RCP    = 1491309;
    localparam int Z_RCP_SH = 26;

    typedef logic signed [RW-1:0] rot_t;
    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [VW-1:0] vec_t;

    typedef struct packed {
        rot_t x;
        rot_t y;
        rot_t z;
    } rot_state_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
    } vec_state_t;

    typedef struct packed {
        q_t q0;
        q_t q1;
        q_t q2;
        q_t q3;
        q_t a1;
        q_t a2;
        q_t a3;
    } qset_t;

    typedef struct packed {
        vec_t bx;
        vec_t by;
        vec_t bz;
        logic und;
    } axis_side_t;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q30 product with floor rounding
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b);
        return q_t'(p >>> IFRAC);
    endfunction

    // Remove the CORDIC gain from a vectoring magnitude
    function automatic vec_t gain_mul(input vec_t x);
        logic signed [VW+31:0] p;
        p = (VW+32)'(x) * (VW+32)'(GAIN_Q30);
        return vec_t'(p >>> IFRAC);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/e2a_rot_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2a_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module e2a_rot_cell
    import e2a_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire rot_state_t d,
    output rot_state_t      q
);

    rot_t dx;
    rot_t dy;
    rot_t dz;
    rot_t xs;
    rot_t ys;
    rot_t at;
    rot_state_t st_next;
    rot_state_t st_reg;

    assign dx = d.x;
    assign dy = d.y;
    assign dz = d.z;

    // Rotate toward zero residual angle
    always_comb
    begin
        xs = dx >>> IDX;
        ys = dy >>> IDX;
        at = rot_t'({4'd0, atan_q30(5'(IDX))});
        if (dz >= 0)
        begin
            st_next.x = dx - ys;
            st_next.y = dy + xs;
            st_next.z = dz - at;
        end
        else
        begin
            st_next.x = dx + ys;
            st_next.y = dy - xs;
            st_next.z = dz + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;

endmodule
`default_nettype wire

// ===== hdl/e2a_vec_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2a_vec_cell
// One vectoring-mode CORDIC micro-rotation, registered. The first cell of a
// lane also folds a vector in the left half plane by a quarter turn.
// ----------------------------------------------------------------------------
module e2a_vec_cell
    import e2a_pkg::*;
#(
    parameter int IDX   = 0,
    parameter bit FIRST = 1'b0
)
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire vec_state_t d,
    output vec_state_t      q
);

    vec_t px;
    vec_t py;
    vec_t pz;
    vec_t xs;
    vec_t ys;
    vec_t at;
    vec_state_t st_next;
    vec_state_t st_reg;

    // Fold the left half plane, then drive y toward zero
    always_comb
    begin
        px = d.x;
        py = d.y;
        pz = d.z;
        if (FIRST && px < 0)
        begin
            px = d.y;
            py = -d.x;
            pz = vec_t'(HALF_PI_Q30);
        end
        xs = px >>> IDX;
        ys = py >>> IDX;
        at = vec_t'({6'd0, atan_q30(5'(IDX))});
        if (py > 0)
        begin
            st_next.x = px + ys;
            st_next.y = py - xs;
            st_next.z = pz + at;
        end
        else
        begin
            st_next.x = px - ys;
            st_next.y = py + xs;
            st_next.z = pz - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;

endmodule
`default_nettype wire

// ===== hdl/euler_to_axis_angle_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_axis_angle_top
// Converts yaw, pitch and roll to rotation angle and axis direction angles
// through a quaternion, using rows of pipelined CORDIC cells.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_ready, yaw/pitch/roll_deg | sink
//   out     | out_valid, out_ready, rot_angle,       | source
//           | axis_angle_x/y/z, axis_undefined       |
//
// One item enters per cycle while the pipeline is not stalled.
// Four CORDIC rows of CORDIC_STAGES cells each lie in series along the pipeline.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
module euler_to_axis_angle_top
    import e2a_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = STAGES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [IN_W-1:0] yaw_deg,
    input  wire logic signed [IN_W-1:0] pitch_deg,
    input  wire logic signed [IN_W-1:0] roll_deg,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [ROT_W-1:0]            rot_angle,
    output logic [AX_W-1:0]             axis_angle_x,
    output logic [AX_W-1:0]             axis_angle_y,
    output logic [AX_W-1:0]             axis_angle_z,
    output logic                        axis_undefined
);

    localparam int S    = CORDIC_STAGES;
    localparam int NSTG = 4*S + 10;
    localparam int SH   = IFRAC - FRAC_BITS;
    localparam int G2_STG = 3*S + 8;

    localparam logic signed [VW:0] RND     = (VW+1)'(64'sd1 <<< (SH-1));
    localparam logic signed [VW:0] TWO_PI  = (VW+1)'(2*PI_Q30);
    localparam logic signed [VW:0] ONE_PI  = (VW+1)'(PI_Q30);

    logic en;
    logic [NSTG-1:0] vld_reg;

    // Advance the whole pipeline when the output can move
    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Angle front end: fold, scale to Q30 radians
    // ------------------------------------------------------------------
    logic signed [IN_W-1:0] ang_in [3];
    assign ang_in[0] = yaw_deg;
    assign ang_in[1] = pitch_deg;
    assign ang_in[2] = roll_deg;

    logic [13:0] a_next   [3];
    logic        sgn_next [3];
    logic        neg_next [3];
    logic [13:0] a_reg    [3];
    logic        sgn0_reg [3];
    logic        neg0_reg [3];
    logic [31:0] base_reg [3];
    logic [19:0] m_reg    [3];
    logic        sgn1_reg [3];
    logic        neg1_reg [3];
    rot_state_t  p2_reg   [3];
    logic        neg2_reg [3];

    // Fold half angles beyond a quarter turn
    always_comb
    begin
        logic signed [15:0] h;
        logic signed [15:0] hf;
        for (int l = 0; l < 3; l++)
        begin
            h = 16'(ang_in[l]);
            neg_next[l] = 1'b1;
            if (h > 16'(QUARTER_TURN))
            begin
                hf = h - 16'(HALF_TURN);
            end
            else if (h < -16'(QUARTER_TURN))
            begin
                hf = h + 16'(HALF_TURN);
            end
            else
            begin
                hf = h;
                neg_next[l] = 1'b0;
            end
            sgn_next[l] = hf[15];
            a_next[l]   = hf[15] ? 14'(-hf) : 14'(hf);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [28:0] rp;
                logic [39:0] tp;
                logic [31:0] zmag;
                // Stage 0: folded magnitude
                a_reg[l]    <= a_next[l];
                sgn0_reg[l] <= sgn_next[l];
                neg0_reg[l] <= neg_next[l];
                // Stage 1: integer part and remainder of the scaling
                rp           = 29'({15'd0, a_reg[l]} * 29'(Z_REM));
                base_reg[l] <= 32'({18'd0, a_reg[l]} * 32'(Z_INT));
                m_reg[l]    <= rp[28:9];
                sgn1_reg[l] <= sgn0_reg[l];
                neg1_reg[l] <= neg0_reg[l];
                // Stage 2: divide remainder by 45, restore sign
                tp   = 40'({20'd0, m_reg[l]} * 40'(Z_RCP));
                zmag = base_reg[l] + 32'(tp[39:Z_RCP_SH]);
                p2_reg[l].x <= rot_t'(GAIN_Q30);
                p2_reg[l].y <= '0;
                p2_reg[l].z <= sgn1_reg[l] ? -rot_t'(zmag) : rot_t'(zmag);
                neg2_reg[l] <= neg1_reg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation rows: half-angle sine and cosine
    // ------------------------------------------------------------------
    rot_state_t rchain [3][S+1];
    logic [2:0] negd_reg [S];

    for (genvar l = 0; l < 3; l++)
    begin : g_rot_lane
        assign rchain[l][0] = p2_reg[l];
        for (genvar k = 0; k < S; k++)
        begin : g_rot_cell
            e2a_rot_cell #(.IDX(k)) u_cell (
                .clk (clk),
                .en  (en),
                .d   (rchain[l][k]),
                .q   (rchain[l][k+1])
            );
        end
    end

    // Carry the fold flags alongside the rows
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negd_reg[0] <= {neg2_reg[2], neg2_reg[1], neg2_reg[0]};
            for (int k = 1; k < S; k++)
            begin
                negd_reg[k] <= negd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quaternion products
    // ------------------------------------------------------------------
    q_t c_reg [3];
    q_t s_reg [3];
    q_t crcp_reg, srsp_reg, srcp_reg, crsp_reg, cy_reg, sy_reg;
    q_t pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg, pg_reg, ph_reg;
    qset_t q3_next;
    qset_t q3_reg;

    always_comb
    begin
        q3_next.q0 = pa_reg + pb_reg;
        q3_next.q1 = pc_reg - pd_reg;
        q3_next.q2 = pg_reg + ph_reg;
        q3_next.q3 = pe_reg - pf_reg;
        q3_next.a1 = q3_next.q1[QW-1] ? -q3_next.q1 : q3_next.q1;
        q3_next.a2 = q3_next.q2[QW-1] ? -q3_next.q2 : q3_next.q2;
        q3_next.a3 = q3_next.q3[QW-1] ? -q3_next.q3 : q3_next.q3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Undo the fold by negating sine and cosine
            for (int l = 0; l < 3; l++)
            begin
                c_reg[l] <= q_t'(negd_reg[S-1][l] ? -rchain[l][S].x : rchain[l][S].x);
                s_reg[l] <= q_t'(negd_reg[S-1][l] ? -rchain[l][S].y : rchain[l][S].y);
            end
            // Pair products: lane 0 yaw, 1 pitch, 2 roll
            crcp_reg <= qmul(c_reg[2], c_reg[1]);
            srsp_reg <= qmul(s_reg[2], s_reg[1]);
            srcp_reg <= qmul(s_reg[2], c_reg[1]);
            crsp_reg <= qmul(c_reg[2], s_reg[1]);
            cy_reg   <= c_reg[0];
            sy_reg   <= s_reg[0];
            // Triple products
            pa_reg <= qmul(crcp_reg, cy_reg);
            pb_reg <= qmul(srsp_reg, sy_reg);
            pc_reg <= qmul(srcp_reg, cy_reg);
            pd_reg <= qmul(crsp_reg, sy_reg);
            pe_reg <= qmul(crcp_reg, sy_reg);
            pf_reg <= qmul(srsp_reg, cy_reg);
            pg_reg <= qmul(crsp_reg, cy_reg);
            ph_reg <= qmul(srcp_reg, sy_reg);
            // Sums and magnitudes
            q3_reg <= q3_next;
        end
    end

    // ------------------------------------------------------------------
    // First vectoring rows: pair magnitudes
    // ------------------------------------------------------------------
    vec_state_t v1chain [3][S+1];
    qset_t      qd1_reg [S];

    assign v1chain[0][0] = '{x: vec_t'(q3_reg.a1), y: vec_t'(q3_reg.a2), z: '0};
    assign v1chain[1][0] = '{x: vec_t'(q3_reg.a2), y: vec_t'(q3_reg.a3), z: '0};
    assign v1chain[2][0] = '{x: vec_t'(q3_reg.a1), y: vec_t'(q3_reg.a3), z: '0};

    for (genvar l = 0; l < 3; l++)
    begin : g_v1_lane
        for (genvar k = 0; k < S; k++)
        begin : g_v1_cell
            e2a_vec_cell #(.IDX(k), .FIRST(k == 0)) u_cell (
                .clk (clk),
                .en  (en),
                .d   (v1chain[l][k]),
                .q   (v1chain[l][k+1])
            );
        end
    end

    vec_t  ma_reg, mb_reg, mc_reg;
    qset_t qg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qd1_reg[0] <= q3_reg;
            for (int k = 1; k < S; k++)
            begin
                qd1_reg[k] <= qd1_reg[k-1];
            end
            // Remove the CORDIC gain
            ma_reg  <= gain_mul(v1chain[0][S].x);
            mb_reg  <= gain_mul(v1chain[1][S].x);
            mc_reg  <= gain_mul(v1chain[2][S].x);
            qg1_reg <= qd1_reg[S-1];
        end
    end

    // ------------------------------------------------------------------
    // Second vectoring rows: sin(alpha/2) and the three axis angles
    // ------------------------------------------------------------------
    vec_state_t v2chain [4][S+1];
    q_t         q0d2_reg [S];
    vec_t       mb_pos, mc_pos, ma_pos;

    assign ma_pos = ma_reg[VW-1] ? '0 : ma_reg;
    assign mb_pos = mb_reg[VW-1] ? '0 : mb_reg;
    assign mc_pos = mc_reg[VW-1] ? '0 : mc_reg;

    assign v2chain[0][0] = '{x: ma_reg,              y: vec_t'(qg1_reg.a3), z: '0};
    assign v2chain[1][0] = '{x: vec_t'(qg1_reg.q1),  y: mb_pos,             z: '0};
    assign v2chain[2][0] = '{x: vec_t'(qg1_reg.q2),  y: mc_pos,             z: '0};
    assign v2chain[3][0] = '{x: vec_t'(qg1_reg.q3),  y: ma_pos,             z: '0};

    for (genvar l = 0; l < 4; l++)
    begin : g_v2_lane
        for (genvar k = 0; k < S; k++)
        begin : g_v2_cell
            e2a_vec_cell #(.IDX(k), .FIRST(k == 0)) u_cell (
                .clk (clk),
                .en  (en),
                .d   (v2chain[l][k]),
                .q   (v2chain[l][k+1])
            );
        end
    end

    vec_t       s_next;
    vec_t       sa_reg;
    q_t         q0g2_reg;
    axis_side_t side_next;
    axis_side_t side_reg;

    // Gain-correct the magnitude and clamp it to nonnegative
    always_comb
    begin
        s_next        = gain_mul(v2chain[0][S].x);
        s_next        = s_next[VW-1] ? '0 : s_next;
        side_next.bx  = v2chain[1][S].z;
        side_next.by  = v2chain[2][S].z;
        side_next.bz  = v2chain[3][S].z;
        side_next.und = (s_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0d2_reg[0] <= qg1_reg.q0;
            for (int k = 1; k < S; k++)
            begin
                q0d2_reg[k] <= q0d2_reg[k-1];
            end
            sa_reg   <= s_next;
            q0g2_reg <= q0d2_reg[S-1];
            side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Third vectoring row: alpha/2 = atan2(s, q0)
    // ------------------------------------------------------------------
    vec_state_t v3chain [S+1];
    axis_side_t sided_reg [S];

    assign v3chain[0] = '{x: vec_t'(q0g2_reg), y: sa_reg, z: '0};

    for (genvar k = 0; k < S; k++)
    begin : g_v3_cell
        e2a_vec_cell #(.IDX(k), .FIRST(k == 0)) u_cell (
            .clk (clk),
            .en  (en),
            .d   (v3chain[k]),
            .q   (v3chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output formatting: clamp, round half up, register
    // ------------------------------------------------------------------
    logic signed [VW:0] rz, xz, yz, zz;
    logic signed [VW:0] rr, xr, yr, zr;
    axis_side_t sd;

    always_comb
    begin
        sd = sided_reg[S-1];
        rz = {v3chain[S].z, 1'b0};
        xz = (VW+1)'(sd.bx);
        yz = (VW+1)'(sd.by);
        zz = (VW+1)'(sd.bz);
        if (rz < 0) rz = '0;
        if (rz > TWO_PI) rz = TWO_PI;
        if (xz < 0) xz = '0;
        if (xz > ONE_PI) xz = ONE_PI;
        if (yz < 0) yz = '0;
        if (yz > ONE_PI) yz = ONE_PI;
        if (zz < 0) zz = '0;
        if (zz > ONE_PI) zz = ONE_PI;
        rr = (rz + RND) >>> SH;
        xr = (xz + RND) >>> SH;
        yr = (yz + RND) >>> SH;
        zr = (zz + RND) >>> SH;
    end

    logic [ROT_W-1:0] rot_angle_reg;
    logic [AX_W-1:0]  axx_reg, axy_reg, axz_reg;
    logic             und_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sided_reg[0] <= side_reg;
            for (int k = 1; k < S; k++)
            begin
                sided_reg[k] <= sided_reg[k-1];
            end
            rot_angle_reg <= rr[ROT_W-1:0];
            axx_reg       <= sd.und ? '0 : xr[AX_W-1:0];
            axy_reg       <= sd.und ? '0 : yr[AX_W-1:0];
            axz_reg       <= sd.und ? '0 : zr[AX_W-1:0];
            und_reg       <= sd.und;
        end
    end

    assign rot_angle      = rot_angle_reg;
    assign axis_angle_x   = axx_reg;
    assign axis_angle_y   = axy_reg;
    assign axis_angle_z   = axz_reg;
    assign axis_undefined = und_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && axis_undefined |->
            axis_angle_x == '0 && axis_angle_y == '0 && axis_angle_z == '0)
        else $error("axis angles nonzero with undefined axis");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_mag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[G2_STG] |-> !sa_reg[VW-1])
        else $error("sin(alpha/2) negative after clamp");

endmodule
`default_nettype wire
